// File: hw/rtl/mcpt_pkg.sv
// ----------------------------------------------------------------------------
// mcpt_pkg
// Shared types, codes and constants for the multichannel PWM table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcpt_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [1:0] MODE_SPARE = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_OFF   = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  localparam logic KIND_PAD = 1'b0;
  localparam logic KIND_ADD = 1'b1;

  localparam logic [13:0] DUTY_FULL  = 14'd10000;
  localparam logic [19:0] DUTY_SCALE = 20'd100;

  // modulo 10^6 reduction constants; MOD_RECIP = floor(2^51 / 10^6)
  localparam logic [21:0] MOD_M     = 22'd1000000;
  localparam logic [21:0] MOD_M2    = 22'd2000000;
  localparam logic [21:0] MOD_M3    = 22'd3000000;
  localparam logic [31:0] MOD_RECIP = 32'd2251799813;
  localparam int          RED_LAT   = 3;

  typedef struct packed {
    logic        operation;
    logic [47:0] time_us;
    logic [7:0]  pad;
    logic [31:0] freq_q16;
    logic [13:0] duty_hundredths;
    logic [31:0] phase_shift;
    logic [1:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pad_out;
    logic       level;
    logic       accepted;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0]  pad;
    logic [31:0] freq;
    logic [13:0] duty;
    logic [31:0] phase;
    logic [1:0]  mode;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic       tail;
    logic       emit;
    logic [7:0] pad;
    logic       level;
  } pipe_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/multichannel_pwm_table.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_table
// Add: the table is scanned, then the response strobes; next start taken that cycle.
// Tick: entries read one per cycle through the table read port into a 10-stage
//   level pipeline; the last result is sent once the pipeline has drained.
// One transaction at a time; results are never held off by the receiver.
// Synchronous reset empties the table (all spare) at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multichannel_pwm_table #(
  parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mcpt_pkg::in_item_t cmd,
  output logic               strobe,
  output mcpt_pkg::result_t  result
);
  import mcpt_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_TICK      = 3'd1;
  localparam logic [2:0] ST_TICK_WAIT = 3'd2;
  localparam logic [2:0] ST_FLUSH     = 3'd3;
  localparam logic [2:0] ST_SCAN      = 3'd4;
  localparam logic [2:0] ST_SCAN_WAIT = 3'd5;
  localparam logic [2:0] ST_ADD_FIN   = 3'd6;

  logic [2:0]       state;
  logic [IDX_W-1:0] cnt;
  in_item_t         item;
  logic             rd_valid_q;
  logic             rd_tail_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             any_match;
  logic             spare_found;
  logic [IDX_W-1:0] spare_idx;
  logic             pend_valid;
  logic [7:0]       pend_pad;
  logic             pend_level;

  logic             rd_en;
  entry_t           rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           new_entry;
  logic             tick_phase;
  logic             scan_phase;
  logic             hit;
  logic             spare_hit;
  pipe_res_t        po;

  assign busy       = (state != ST_IDLE);
  assign rd_en      = (state == ST_TICK) || (state == ST_SCAN);
  assign tick_phase = (state == ST_TICK) || (state == ST_TICK_WAIT);
  assign scan_phase = (state == ST_SCAN) || (state == ST_SCAN_WAIT);

  assign hit       = scan_phase && rd_valid_q && (rd_data.mode != MODE_SPARE) &&
                     (rd_data.pad == item.pad);
  assign spare_hit = scan_phase && rd_valid_q && (rd_data.mode == MODE_SPARE) &&
                     !spare_found;

  assign new_entry.pad   = item.pad;
  assign new_entry.freq  = item.freq_q16;
  assign new_entry.duty  = (item.duty_hundredths > DUTY_FULL) ? DUTY_FULL
                                                              : item.duty_hundredths;
  assign new_entry.phase = item.phase_shift;
  assign new_entry.mode  = item.mode;

  assign wr_en   = hit || ((state == ST_ADD_FIN) && !any_match && spare_found);
  assign wr_addr = hit ? rd_idx_q : spare_idx;

  mcpt_table #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (new_entry)
  );

  mcpt_level u_level (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_phase && rd_valid_q),
    .tail     (rd_tail_q),
    .entry    (rd_data),
    .time_us  (item.time_us),
    .res      (po)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      rd_valid_q  <= 1'b0;
      any_match   <= 1'b0;
      spare_found <= 1'b0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      rd_valid_q <= rd_en;
      case (state)
        ST_IDLE: begin
          cnt         <= '0;
          any_match   <= 1'b0;
          spare_found <= 1'b0;
          pend_valid  <= 1'b0;
          if (start) begin
            state <= (cmd.operation == OP_ADD) ? ST_SCAN : ST_TICK;
          end
        end
        ST_TICK: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= ST_TICK_WAIT;
          end
        end
        ST_TICK_WAIT: begin
          state <= ST_TICK_WAIT;
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= ST_SCAN_WAIT;
          end
        end
        ST_SCAN_WAIT: begin
          state <= ST_ADD_FIN;
        end
        ST_ADD_FIN: begin
          strobe <= 1'b1;
          state  <= ST_IDLE;
        end
        ST_FLUSH: begin
          strobe     <= pend_valid;
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (hit) begin
        any_match <= 1'b1;
      end
      if (spare_hit) begin
        spare_found <= 1'b1;
      end
      // hold one result back so the final one can carry last
      if (tick_phase && po.valid) begin
        if (po.emit) begin
          strobe     <= pend_valid;
          pend_valid <= 1'b1;
        end
        if (po.tail) begin
          state <= ST_FLUSH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      item <= cmd;
    end
    rd_tail_q <= (cnt == LAST_IDX);
    rd_idx_q  <= cnt;
    if (spare_hit) begin
      spare_idx <= rd_idx_q;
    end
    if (tick_phase && po.valid && po.emit) begin
      pend_pad   <= po.pad;
      pend_level <= po.level;
    end
    if (state == ST_ADD_FIN) begin
      result.kind     <= KIND_ADD;
      result.pad_out  <= item.pad;
      result.level    <= 1'b0;
      result.accepted <= any_match || spare_found;
      result.last     <= 1'b1;
    end else begin
      result.kind     <= KIND_PAD;
      result.pad_out  <= pend_pad;
      result.level    <= pend_level;
      result.accepted <= 1'b0;
      result.last     <= (state == ST_FLUSH);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mcpt_mod1e6.sv
// ----------------------------------------------------------------------------
// mcpt_mod1e6
// Three-stage pipelined reduction of a 52-bit value modulo 10^6.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpt_mod1e6 (
  input  logic        clk,
  input  logic [51:0] x,
  output logic [19:0] r
);
  import mcpt_pkg::*;

  logic [63:0] qprod;
  logic [21:0] q1;
  logic [21:0] xl1;
  logic [43:0] qm;
  logic [21:0] r2;
  logic [21:0] r3;

  // quotient estimate is low by at most three
  assign qprod = x[51:20] * MOD_RECIP;
  assign qm    = q1 * MOD_M;

  always_comb begin
    if (r2 >= MOD_M3) begin
      r3 = r2 - MOD_M3;
    end else if (r2 >= MOD_M2) begin
      r3 = r2 - MOD_M2;
    end else if (r2 >= MOD_M) begin
      r3 = r2 - MOD_M;
    end else begin
      r3 = r2;
    end
  end

  always_ff @(posedge clk) begin
    q1  <= qprod[52:31];
    xl1 <= x[21:0];
    r2  <= xl1 - qm[21:0];
    r   <= r3[19:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/mcpt_table.sv
// ----------------------------------------------------------------------------
// mcpt_table
// Channel table memory, one read and one write port, registered read data.
// Entries never written read as zero (spare).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpt_table #(
  parameter int NUM_CHANNELS = mcpt_pkg::NUM_CHANNELS_DEF,
  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output mcpt_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  mcpt_pkg::entry_t     wr_data
);
  import mcpt_pkg::*;

  entry_t                  mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] entry_vld;
  entry_t                  rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= entry_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/mcpt_level.sv
// ----------------------------------------------------------------------------
// mcpt_level
// Ten-stage level pipeline, one entry per cycle.
// level = on && (((time + phase) * freq >> 16) mod 10^6 < duty * 100)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcpt_level (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                tail,
  input  mcpt_pkg::entry_t    entry,
  input  logic [47:0]         time_us,
  output mcpt_pkg::pipe_res_t res
);
  import mcpt_pkg::*;

  typedef struct packed {
    logic [7:0]  pad;
    logic        on;
    logic        emit;
    logic        tail;
    logic [19:0] d100;
  } side_t;

  side_t              side_in;
  logic               v1;
  side_t              side1;
  logic [48:0]        s1;
  logic [31:0]        f1;
  logic [47:0]        prod_lo;

  logic [RED_LAT-1:0] va;
  side_t              side_a [RED_LAT];
  logic [31:0]        f_a    [RED_LAT];
  logic [31:0]        wlo_a  [RED_LAT];
  logic [19:0]        t_r;

  logic               v5;
  side_t              side5;
  logic [51:0]        hi5;
  logic [31:0]        wlo5;

  logic               v6;
  side_t              side6;
  logic [51:0]        x6;

  logic [RED_LAT-1:0] vb;
  side_t              side_b [RED_LAT];
  logic [19:0]        q_r;

  assign side_in.pad  = entry.pad;
  assign side_in.on   = (entry.mode == MODE_ON);
  assign side_in.emit = (entry.mode == MODE_ON) || (entry.mode == MODE_OFF);
  assign side_in.tail = tail;
  assign side_in.d100 = {6'd0, entry.duty} * DUTY_SCALE;

  assign prod_lo = s1[15:0] * f1;

  mcpt_mod1e6 u_red_a (
    .clk (clk),
    .x   ({19'd0, s1[48:16]}),
    .r   (t_r)
  );

  mcpt_mod1e6 u_red_b (
    .clk (clk),
    .x   (x6),
    .r   (q_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      va        <= '0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      vb        <= '0;
    end else begin
      v1        <= in_valid;
      va        <= {va[RED_LAT-2:0], v1};
      v5        <= va[RED_LAT-1];
      v6        <= v5;
      vb        <= {vb[RED_LAT-2:0], v6};
    end
  end

  always_ff @(posedge clk) begin
    side1 <= side_in;
    s1    <= {1'b0, time_us} + {17'd0, entry.phase};
    f1    <= entry.freq;

    side_a[0] <= side1;
    f_a[0]    <= f1;
    wlo_a[0]  <= prod_lo[47:16];
    for (int i = 1; i < RED_LAT; i++) begin
      side_a[i] <= side_a[i-1];
      f_a[i]    <= f_a[i-1];
      wlo_a[i]  <= wlo_a[i-1];
    end

    side5 <= side_a[RED_LAT-1];
    hi5   <= t_r * f_a[RED_LAT-1];
    wlo5  <= wlo_a[RED_LAT-1];

    side6 <= side5;
    x6    <= hi5 + {20'd0, wlo5};

    side_b[0] <= side6;
    for (int i = 1; i < RED_LAT; i++) begin
      side_b[i] <= side_b[i-1];
    end

    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= vb[RED_LAT-1];
    end
    res.tail  <= side_b[RED_LAT-1].tail;
    res.emit  <= side_b[RED_LAT-1].emit;
    res.pad   <= side_b[RED_LAT-1].pad;
    res.level <= side_b[RED_LAT-1].on && (q_r < side_b[RED_LAT-1].d100);
  end

endmodule

`default_nettype wire
